// ----- rtl/etp_pkg.sv -----
// ============================================================================
// etp_pkg: shared types and constants of the edge taper window
// Widths, CORDIC constants, the arctangent table and the state types used by
// the record tracker, the taper factor unit and the top level.
// ============================================================================
package etp_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int INDEX_BITS   = 20;
    localparam int FACTOR_BITS  = 16;
    localparam int CFG_BITS     = 21;
    localparam int PHASE_BITS   = 24;
    localparam int CORDIC_STEPS = 30;
    localparam int ANGLE_BITS   = 31;
    localparam int ACC_BITS     = 33;
    localparam int PROD_BITS    = 2 * ANGLE_BITS;
    localparam int REM_BITS     = CFG_BITS + 1;
    localparam int STEP_BITS    = 5;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [ANGLE_BITS-1:0] HALF_PI_Q30         = 31'd1686629713;
    localparam logic [ANGLE_BITS-1:0] CORDIC_INV_GAIN_Q30 = 31'd652032874;
    localparam logic [ANGLE_BITS-1:0] ONE_Q30             = 31'd1073741824;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RECORD_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_TAPER   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END_TAPER     = 2'd2;

    localparam logic [CFG_BITS-1:0] RESET_RECORD_LENGTH = 21'd1024;

    // Per-sample decision handed from the record tracker to the top level.
    typedef struct packed {
        logic                  last;
        logic                  bad;
        logic                  taper;
        logic [INDEX_BITS-1:0] k;
        logic [CFG_BITS-1:0]   n;
    } t_rec_info;

    typedef enum logic [2:0] {
        FAC_IDLE,
        FAC_DIV,
        FAC_ZMUL,
        FAC_LOAD,
        FAC_ROT,
        FAC_SQR,
        FAC_SAT
    } t_fac_state;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_FACTOR,
        TOP_SCALE_RE,
        TOP_SCALE_IM,
        TOP_OUT
    } t_top_state;

    // Rounded arctangent of 2^-i in Q30.
    function automatic logic [ANGLE_BITS-1:0] atan_q30(input logic [STEP_BITS-1:0] i);
        logic [ANGLE_BITS-1:0] v;
        case (i)
            5'd0:    v = 31'd843314857;
            5'd1:    v = 31'd497837830;
            5'd2:    v = 31'd263043837;
            5'd3:    v = 31'd133525159;
            5'd4:    v = 31'd67021687;
            5'd5:    v = 31'd33543516;
            5'd6:    v = 31'd16775851;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194283;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048576;
            5'd11:   v = 31'd524288;
            5'd12:   v = 31'd262144;
            5'd13:   v = 31'd131072;
            5'd14:   v = 31'd65536;
            5'd15:   v = 31'd32768;
            5'd16:   v = 31'd16384;
            5'd17:   v = 31'd8192;
            5'd18:   v = 31'd4096;
            5'd19:   v = 31'd2048;
            5'd20:   v = 31'd1024;
            5'd21:   v = 31'd512;
            5'd22:   v = 31'd256;
            5'd23:   v = 31'd128;
            5'd24:   v = 31'd64;
            5'd25:   v = 31'd32;
            5'd26:   v = 31'd16;
            5'd27:   v = 31'd8;
            5'd28:   v = 31'd4;
            5'd29:   v = 31'd2;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/edge_taper_window.sv -----
// ============================================================================
// edge_taper_window: Tukey-style edge taper over records of complex samples
// Scales the first and last samples of each record by a half-cosine ramp.
// ============================================================================
// Usage: samples enter on the input channel (i_valid / o_ready) as a real and
// an imaginary part and leave on the output channel (o_valid / i_ready) with
// the record end and bad setting flags, one result item per input item, in
// order. The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes a
// register; write it only while no item is in flight. The block takes one
// item at a time. An unscaled item moves from the input registers into the
// output register. A tapered item passes in order through restoring division
// for the ramp phase, a multiply to the angle, a rotator load, 30 CORDIC
// steps, a square, a round and saturate, the factor handover, real then
// imaginary scaling on one multiplier, and the move into the output register.
// Once either kind of item moves into the output register, the block can take
// the next item.
// A new item is taken while a finished result still waits in the output
// register; if the receiver stalls, the next result waits in the block and
// no further item is accepted until the output register frees. Reset clears
// the position, loads record_length 1024 with no taper and empties the output.
// ============================================================================
module edge_taper_window (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [etp_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [etp_pkg::CFG_BITS-1:0]          i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [etp_pkg::SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [etp_pkg::SAMPLE_BITS-1:0] i_sample_im,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [etp_pkg::SAMPLE_BITS-1:0] o_out_re,
    output logic signed [etp_pkg::SAMPLE_BITS-1:0] o_out_im,
    output logic                                  o_record_end,
    output logic                                  o_bad_setting
);

    localparam int SCALE_BITS = etp_pkg::SAMPLE_BITS + etp_pkg::FACTOR_BITS + 1;

    etp_pkg::t_top_state r_state;
    etp_pkg::t_top_state n_state;

    etp_pkg::t_rec_info rec_info;

    logic accept;
    logic out_free;
    logic out_load;
    logic fac_start;
    logic fac_done;
    logic [etp_pkg::FACTOR_BITS-1:0] fac_value;

    logic signed [etp_pkg::SAMPLE_BITS-1:0] r_res_re;
    logic signed [etp_pkg::SAMPLE_BITS-1:0] r_res_im;
    logic                                   r_last;
    logic                                   r_bad;
    logic                                   r_out_valid;
    logic signed [etp_pkg::SAMPLE_BITS-1:0] r_out_re;
    logic signed [etp_pkg::SAMPLE_BITS-1:0] r_out_im;
    logic                                   r_out_last;
    logic                                   r_out_bad;

    logic signed [etp_pkg::SAMPLE_BITS-1:0] scale_in;
    logic signed [SCALE_BITS-1:0]           scale_prod;
    logic signed [SCALE_BITS-1:0]           scale_rnd;
    logic signed [etp_pkg::SAMPLE_BITS-1:0] scale_out;

    // Position and the taper decision advance with every accepted item.
    etp_record u_record (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (accept),
        .o_info      (rec_info)
    );

    etp_factor u_factor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (fac_start),
        .i_k      (rec_info.k),
        .i_n      (rec_info.n),
        .o_done   (fac_done),
        .o_factor (fac_value)
    );

    assign o_ready   = (r_state == etp_pkg::TOP_IDLE);
    assign accept    = i_valid && o_ready;
    assign fac_start = accept && rec_info.taper;
    assign out_free  = !r_out_valid || i_ready;
    assign out_load  = (r_state == etp_pkg::TOP_OUT) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etp_pkg::TOP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            etp_pkg::TOP_IDLE: begin
                if (accept) begin
                    n_state = rec_info.taper ? etp_pkg::TOP_FACTOR : etp_pkg::TOP_OUT;
                end
            end
            etp_pkg::TOP_FACTOR:   if (fac_done) n_state = etp_pkg::TOP_SCALE_RE;
            etp_pkg::TOP_SCALE_RE: n_state = etp_pkg::TOP_SCALE_IM;
            etp_pkg::TOP_SCALE_IM: n_state = etp_pkg::TOP_OUT;
            etp_pkg::TOP_OUT:      if (out_free) n_state = etp_pkg::TOP_IDLE;
            default:               n_state = etp_pkg::TOP_IDLE;
        endcase
    end

    // One multiplier scales the real part, then the imaginary part, with
    // round half up and a floor shift back to the sample width.
    always_comb begin
        scale_in   = (r_state == etp_pkg::TOP_SCALE_IM) ? r_res_im : r_res_re;
        scale_prod = scale_in * $signed({1'b0, fac_value});
        scale_rnd  = scale_prod + (SCALE_BITS'(1) << (etp_pkg::FACTOR_BITS - 1));
        scale_out  = etp_pkg::SAMPLE_BITS'(scale_rnd >>> etp_pkg::FACTOR_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_re <= i_sample_re;
            r_res_im <= i_sample_im;
            r_last   <= rec_info.last;
            r_bad    <= rec_info.bad;
        end else if (r_state == etp_pkg::TOP_SCALE_RE) begin
            r_res_re <= scale_out;
        end else if (r_state == etp_pkg::TOP_SCALE_IM) begin
            r_res_im <= scale_out;
        end
        if (out_load) begin
            r_out_re   <= r_res_re;
            r_out_im   <= r_res_im;
            r_out_last <= r_last;
            r_out_bad  <= r_bad;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_re      = r_out_re;
    assign o_out_im      = r_out_im;
    assign o_record_end  = r_out_last;
    assign o_bad_setting = r_out_bad;

endmodule

// ----- rtl/etp_record.sv -----
// ============================================================================
// etp_record: configuration registers and record position tracking
// Holds the three configuration registers and the position in the record,
// and decides for the sample at hand whether and how it is tapered.
// ============================================================================
module etp_record (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [etp_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [etp_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic                                i_advance,
    output etp_pkg::t_rec_info                  o_info
);

    localparam logic [etp_pkg::CFG_BITS-1:0] LEN_CAP =
        etp_pkg::CFG_BITS'(1) << etp_pkg::INDEX_BITS;

    logic [etp_pkg::CFG_BITS-1:0]   r_record_length;
    logic [etp_pkg::CFG_BITS-1:0]   r_start_taper;
    logic [etp_pkg::CFG_BITS-1:0]   r_end_taper;
    logic [etp_pkg::INDEX_BITS-1:0] r_position;
    logic [etp_pkg::INDEX_BITS-1:0] n_position;

    logic [etp_pkg::CFG_BITS-1:0]   len;
    logic [etp_pkg::INDEX_BITS-1:0] len_m1;
    logic [etp_pkg::INDEX_BITS-1:0] pos;
    logic [etp_pkg::INDEX_BITS-1:0] back;
    logic                           last;
    logic                           bad;
    logic                           take_start;
    logic                           take_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_length <= etp_pkg::RESET_RECORD_LENGTH;
            r_start_taper   <= '0;
            r_end_taper     <= '0;
            r_position      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    etp_pkg::CFG_RECORD_LENGTH: r_record_length <= i_cfg_data;
                    etp_pkg::CFG_START_TAPER:   r_start_taper   <= i_cfg_data;
                    etp_pkg::CFG_END_TAPER:     r_end_taper     <= i_cfg_data;
                    default:                    ;
                endcase
            end
            if (i_advance) begin
                r_position <= n_position;
            end
        end
    end

    always_comb begin
        // A zero length acts as one, an overlong one as the position range.
        if (r_record_length == '0) begin
            len = etp_pkg::CFG_BITS'(1);
        end else if (r_record_length > LEN_CAP) begin
            len = LEN_CAP;
        end else begin
            len = r_record_length;
        end
        len_m1 = etp_pkg::INDEX_BITS'(len - etp_pkg::CFG_BITS'(1));
        // A position left beyond a shortened record counts as its last sample.
        pos  = (r_position > len_m1) ? len_m1 : r_position;
        last = (pos == len_m1);
        back = len_m1 - pos;
        bad  = ({r_start_taper, 1'b0} >= {1'b0, len}) ||
               ({r_end_taper, 1'b0} >= {1'b0, len});
        take_start = ({1'b0, pos} < r_start_taper);
        take_end   = ({1'b0, back} < r_end_taper);
        n_position = last ? '0 : pos + etp_pkg::INDEX_BITS'(1);

        o_info.last  = last;
        o_info.bad   = bad;
        o_info.taper = !bad && (take_start || take_end);
        o_info.k     = take_start ? pos : back;
        o_info.n     = take_start ? r_start_taper : r_end_taper;
    end

endmodule

// ----- rtl/etp_factor.sv -----
// ============================================================================
// etp_factor: iterative taper factor unit
// Computes round(sin(pi/2 * k/n)^2) in Q0.16 with a restoring divider, one
// shared multiplier and a CORDIC rotator, all stepped by a small sequencer.
// ============================================================================
module etp_factor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [etp_pkg::INDEX_BITS-1:0]      i_k,
    input  logic [etp_pkg::CFG_BITS-1:0]        i_n,
    output logic                                o_done,
    output logic [etp_pkg::FACTOR_BITS-1:0]     o_factor
);

    localparam logic [etp_pkg::STEP_BITS-1:0] DIV_LAST =
        etp_pkg::STEP_BITS'(etp_pkg::PHASE_BITS - 1);
    localparam logic [etp_pkg::STEP_BITS-1:0] ROT_LAST =
        etp_pkg::STEP_BITS'(etp_pkg::CORDIC_STEPS - 1);
    localparam int ROUND_SHIFT = 2 * 30 - etp_pkg::FACTOR_BITS;
    localparam int FULL_BITS   = etp_pkg::PROD_BITS + 1 - ROUND_SHIFT;

    etp_pkg::t_fac_state r_state;
    etp_pkg::t_fac_state n_state;

    logic [etp_pkg::REM_BITS-1:0]    r_rem;
    logic [etp_pkg::CFG_BITS-1:0]    r_den;
    logic [etp_pkg::PHASE_BITS-1:0]  r_quo;
    logic [etp_pkg::STEP_BITS-1:0]   r_cnt;
    logic signed [etp_pkg::ACC_BITS-1:0] r_x;
    logic signed [etp_pkg::ACC_BITS-1:0] r_y;
    logic signed [etp_pkg::ACC_BITS-1:0] r_z;
    logic [etp_pkg::PROD_BITS-1:0]   r_prod;
    logic [etp_pkg::FACTOR_BITS-1:0] r_factor;
    logic                            r_done;

    logic [etp_pkg::REM_BITS-1:0]    rem2;
    logic [etp_pkg::REM_BITS-1:0]    rem_diff;
    logic                            quo_bit;
    logic signed [etp_pkg::ACC_BITS-1:0] dx;
    logic signed [etp_pkg::ACC_BITS-1:0] dy;
    logic signed [etp_pkg::ACC_BITS-1:0] atan_ext;
    logic [etp_pkg::ANGLE_BITS-1:0]  sin_val;
    logic [etp_pkg::ANGLE_BITS-1:0]  mul_a;
    logic [etp_pkg::ANGLE_BITS-1:0]  mul_b;
    logic [etp_pkg::PROD_BITS:0]     rounded;
    logic [FULL_BITS-1:0]            fac_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etp_pkg::FAC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == etp_pkg::FAC_SAT);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            etp_pkg::FAC_IDLE: if (i_start) n_state = etp_pkg::FAC_DIV;
            etp_pkg::FAC_DIV:  if (r_cnt == DIV_LAST) n_state = etp_pkg::FAC_ZMUL;
            etp_pkg::FAC_ZMUL: n_state = etp_pkg::FAC_LOAD;
            etp_pkg::FAC_LOAD: n_state = etp_pkg::FAC_ROT;
            etp_pkg::FAC_ROT:  if (r_cnt == ROT_LAST) n_state = etp_pkg::FAC_SQR;
            etp_pkg::FAC_SQR:  n_state = etp_pkg::FAC_SAT;
            etp_pkg::FAC_SAT:  n_state = etp_pkg::FAC_IDLE;
            default:           n_state = etp_pkg::FAC_IDLE;
        endcase
    end

    always_comb begin
        // One quotient bit per cycle; the remainder always stays below n.
        rem2     = {r_rem[etp_pkg::REM_BITS-2:0], 1'b0};
        rem_diff = rem2 - {1'b0, r_den};
        quo_bit  = (rem2 >= {1'b0, r_den});

        // Floor shifts of the CORDIC rotation.
        dx       = r_y >>> r_cnt;
        dy       = r_x >>> r_cnt;
        atan_ext = $signed({2'b00, etp_pkg::atan_q30(r_cnt)});

        // Sine clamped to [0, 1.0] in Q30.
        if (r_y[etp_pkg::ACC_BITS-1]) begin
            sin_val = '0;
        end else if (r_y > $signed({2'b00, etp_pkg::ONE_Q30})) begin
            sin_val = etp_pkg::ONE_Q30;
        end else begin
            sin_val = r_y[etp_pkg::ANGLE_BITS-1:0];
        end

        // The one multiplier: phase to angle, then sine squared.
        if (r_state == etp_pkg::FAC_SQR) begin
            mul_a = sin_val;
            mul_b = sin_val;
        end else begin
            mul_a = etp_pkg::ANGLE_BITS'(r_quo);
            mul_b = etp_pkg::HALF_PI_Q30;
        end

        rounded  = {1'b0, r_prod} +
                   ((etp_pkg::PROD_BITS + 1)'(1) << (ROUND_SHIFT - 1));
        fac_full = rounded[etp_pkg::PROD_BITS:ROUND_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            etp_pkg::FAC_IDLE: begin
                r_rem <= etp_pkg::REM_BITS'(i_k);
                r_den <= i_n;
                r_quo <= '0;
                r_cnt <= '0;
            end
            etp_pkg::FAC_DIV: begin
                r_rem <= quo_bit ? rem_diff : rem2;
                r_quo <= {r_quo[etp_pkg::PHASE_BITS-2:0], quo_bit};
                r_cnt <= r_cnt + etp_pkg::STEP_BITS'(1);
            end
            etp_pkg::FAC_ZMUL: begin
                r_prod <= mul_a * mul_b;
            end
            etp_pkg::FAC_LOAD: begin
                r_z   <= $signed({2'b00,
                    r_prod[etp_pkg::PHASE_BITS+etp_pkg::ANGLE_BITS-1:etp_pkg::PHASE_BITS]});
                r_x   <= $signed({2'b00, etp_pkg::CORDIC_INV_GAIN_Q30});
                r_y   <= '0;
                r_cnt <= '0;
            end
            etp_pkg::FAC_ROT: begin
                if (!r_z[etp_pkg::ACC_BITS-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_ext;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_ext;
                end
                r_cnt <= r_cnt + etp_pkg::STEP_BITS'(1);
            end
            etp_pkg::FAC_SQR: begin
                r_prod <= mul_a * mul_b;
            end
            etp_pkg::FAC_SAT: begin
                if (fac_full > FULL_BITS'({etp_pkg::FACTOR_BITS{1'b1}})) begin
                    r_factor <= '1;
                end else begin
                    r_factor <= fac_full[etp_pkg::FACTOR_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_factor = r_factor;

endmodule
